@@ sv/lpp_pkg.sv @@
// ----------------------------------------------------------------------------
// lpp_pkg: shared constants for the lidar packet parser
// Register indexes, reset values, field widths and packet layout defaults.
// ----------------------------------------------------------------------------
`default_nettype none

package lpp_pkg;

    // Field widths
    localparam int BYTE_W  = 8;
    localparam int ANGLE_W = 16;
    localparam int SPEED_W = 16;
    localparam int DIST_W  = 14;
    localparam int FLAGS_W = 8;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_START_BYTE   = 2'd0,
        REG_INDEX_BIAS   = 2'd1,
        REG_INVALID_MASK = 2'd2
    } cfg_reg_t;

    localparam logic [CFG_DATA_W-1:0] START_BYTE_RST   = 8'd250;
    localparam logic [CFG_DATA_W-1:0] INDEX_BIAS_RST   = 8'd160;
    localparam logic [CFG_DATA_W-1:0] INVALID_MASK_RST = 8'd128;

    // Packet layout
    localparam int PACKET_LEN_DEF = 22;
    localparam int SPEED_POS_DEF  = 2;
    localparam int INDEX_POS      = 1;
    localparam int READINGS       = 4;
    localparam int FIRST_READING  = 4;
    localparam int READING_STRIDE = 4;

    // Upper distance bits kept from each reading's high byte
    localparam int DIST_HI_W = DIST_W - BYTE_W;

    // Angle is the index difference times four
    localparam int ANGLE_SHIFT = 2;

endpackage

`default_nettype wire

@@ sv/lidar_packet_parser.sv @@
// ----------------------------------------------------------------------------
// lidar_packet_parser: serial packet parser for a rotating range scanner
// Collects fixed-length packets from a byte stream and emits angle, speed
// and four distance readings with their error flags per packet.
// ----------------------------------------------------------------------------
// Usage:
//   s_* channel carries one received byte per transaction (valid/ready).
//   While hunting, bytes are dropped until one equals start_byte; that byte
//   and the next PACKET_LEN-1 bytes form a packet. A start byte inside a
//   packet is plain data.
//   m_* channel carries one result per completed packet (valid/ready).
//   Timing: the last byte of a packet is loaded into the input register,
//   then the result register is loaded from the decode stage; a full
//   result register that is not being read holds that byte back.
//   Throughput: one byte per cycle while no completing byte is held. The
//   input register and the result register are separate stages, so bytes
//   keep flowing while a result waits.
//   Stall: a completing byte waits in the input register only while the
//   result register is still full and m_ready is low; other bytes pass.
//   Reset (aresetn low, synchronous): both channels empty, parser hunting,
//   registers at start_byte 250, index_bias 160, invalid_mask 128.
//   Configuration: cfg_wr_en writes register cfg_index (0 start_byte,
//   1 index_bias, 2 invalid_mask); index 3 is ignored.
// ----------------------------------------------------------------------------
`default_nettype none

module lidar_packet_parser #(
    parameter int PACKET_LEN = lpp_pkg::PACKET_LEN_DEF,
    parameter int SPEED_POS  = lpp_pkg::SPEED_POS_DEF
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,

    input  wire logic                              cfg_wr_en,
    input  wire logic [lpp_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [lpp_pkg::CFG_DATA_W-1:0]    cfg_data,

    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic [lpp_pkg::BYTE_W-1:0]        s_rx_byte,

    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic [lpp_pkg::ANGLE_W-1:0]            m_base_angle,
    output logic [lpp_pkg::SPEED_W-1:0]            m_speed_raw,
    output logic [lpp_pkg::DIST_W-1:0]             m_distance_a,
    output logic [lpp_pkg::DIST_W-1:0]             m_distance_b,
    output logic [lpp_pkg::DIST_W-1:0]             m_distance_c,
    output logic [lpp_pkg::DIST_W-1:0]             m_distance_d,
    output logic [lpp_pkg::FLAGS_W-1:0]            m_flags_a,
    output logic [lpp_pkg::FLAGS_W-1:0]            m_flags_b,
    output logic [lpp_pkg::FLAGS_W-1:0]            m_flags_c,
    output logic [lpp_pkg::FLAGS_W-1:0]            m_flags_d
);

    localparam int BW    = lpp_pkg::BYTE_W;
    localparam int POS_W = $clog2(PACKET_LEN);
    localparam int NR    = lpp_pkg::READINGS;
    localparam logic [POS_W-1:0] LAST_POS = POS_W'(PACKET_LEN - 1);

    // Configuration registers
    logic [BW-1:0] start_byte_reg;
    logic [BW-1:0] index_bias_reg;
    logic [BW-1:0] invalid_mask_reg;

    // Input stage
    logic          in_valid_reg;
    logic [BW-1:0] in_byte_reg;

    // Parser state
    logic             hunting_reg;
    logic [POS_W-1:0] pos_reg;
    logic [BW-1:0]    packet_store_reg [PACKET_LEN];

    // Result stage
    logic                              m_valid_reg;
    logic [lpp_pkg::ANGLE_W-1:0]       angle_reg;
    logic [lpp_pkg::SPEED_W-1:0]       speed_reg;
    logic [lpp_pkg::DIST_W-1:0]        dist_reg  [NR];
    logic [lpp_pkg::FLAGS_W-1:0]       flags_reg [NR];

    logic [lpp_pkg::ANGLE_W-1:0]       angle_next;
    logic [lpp_pkg::SPEED_W-1:0]       speed_next;
    logic [lpp_pkg::DIST_W-1:0]        dist_next  [NR];
    logic [lpp_pkg::FLAGS_W-1:0]       flags_next [NR];
    logic [lpp_pkg::ANGLE_W-1:0]       index_diff;

    logic is_start;
    logic store_en;
    logic complete;
    logic advance;
    logic accept_in;

    assign is_start  = (in_byte_reg == start_byte_reg);
    assign store_en  = in_valid_reg && (!hunting_reg || is_start);
    assign complete  = in_valid_reg && !hunting_reg && (pos_reg == LAST_POS);
    // hold a completing byte while the result register is still occupied and m_ready is low
    assign advance   = !complete || !m_valid_reg || m_ready;
    assign s_ready   = !in_valid_reg || advance;
    assign accept_in = s_valid && s_ready;

    // Decode of the stored packet; all bytes read here are stored before the
    // last byte arrives
    always_comb begin
        index_diff = {{(lpp_pkg::ANGLE_W - BW){1'b0}}, packet_store_reg[lpp_pkg::INDEX_POS]}
                   - {{(lpp_pkg::ANGLE_W - BW){1'b0}}, index_bias_reg};
        angle_next = {index_diff[lpp_pkg::ANGLE_W-lpp_pkg::ANGLE_SHIFT-1:0],
                      {lpp_pkg::ANGLE_SHIFT{1'b0}}};
        speed_next = {packet_store_reg[SPEED_POS + 1], packet_store_reg[SPEED_POS]};
    end

    for (genvar i = 0; i < NR; i++) begin : g_reading
        localparam int LO = lpp_pkg::FIRST_READING + lpp_pkg::READING_STRIDE * i;
        always_comb begin
            flags_next[i] = packet_store_reg[LO + 1] & invalid_mask_reg;
            if (flags_next[i] == '0) begin
                dist_next[i] = {packet_store_reg[LO + 1][lpp_pkg::DIST_HI_W-1:0],
                                packet_store_reg[LO]};
            end else begin
                dist_next[i] = '0;
            end
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_byte_reg   <= lpp_pkg::START_BYTE_RST;
            index_bias_reg   <= lpp_pkg::INDEX_BIAS_RST;
            invalid_mask_reg <= lpp_pkg::INVALID_MASK_RST;
            in_valid_reg     <= 1'b0;
            hunting_reg      <= 1'b1;
            pos_reg          <= '0;
            m_valid_reg      <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    lpp_pkg::REG_START_BYTE:   start_byte_reg   <= cfg_data;
                    lpp_pkg::REG_INDEX_BIAS:   index_bias_reg   <= cfg_data;
                    lpp_pkg::REG_INVALID_MASK: invalid_mask_reg <= cfg_data;
                    default: ;
                endcase
            end

            if (accept_in) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end

            if (store_en && advance) begin
                if (complete) begin
                    hunting_reg <= 1'b1;
                    pos_reg     <= '0;
                end else begin
                    hunting_reg <= 1'b0;
                    pos_reg     <= pos_reg + POS_W'(1);
                end
            end

            if (complete && advance) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Payload: input byte, packet bytes and result fields
    always_ff @(posedge aclk) begin
        if (accept_in) begin
            in_byte_reg <= s_rx_byte;
        end
        if (store_en && advance) begin
            packet_store_reg[pos_reg] <= in_byte_reg;
        end
        if (complete && advance) begin
            angle_reg <= angle_next;
            speed_reg <= speed_next;
            for (int i = 0; i < NR; i++) begin
                dist_reg[i]  <= dist_next[i];
                flags_reg[i] <= flags_next[i];
            end
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_base_angle = angle_reg;
    assign m_speed_raw  = speed_reg;
    assign m_distance_a = dist_reg[0];
    assign m_distance_b = dist_reg[1];
    assign m_distance_c = dist_reg[2];
    assign m_distance_d = dist_reg[3];
    assign m_flags_a    = flags_reg[0];
    assign m_flags_b    = flags_reg[1];
    assign m_flags_c    = flags_reg[2];
    assign m_flags_d    = flags_reg[3];

endmodule

`default_nettype wire

@@ sv/lpp_checker.sv @@
// ----------------------------------------------------------------------------
// lpp_checker: port-level checks for the lidar packet parser
// Watches the top level's ports and flags protocol or decode slips.
// ----------------------------------------------------------------------------
`default_nettype none

module lpp_checker (
    input wire logic                              aclk,
    input wire logic                              aresetn,
    input wire logic                              s_ready,
    input wire logic                              m_valid,
    input wire logic                              m_ready,
    input wire logic [lpp_pkg::ANGLE_W-1:0]       m_base_angle,
    input wire logic [lpp_pkg::SPEED_W-1:0]       m_speed_raw,
    input wire logic [lpp_pkg::DIST_W-1:0]        m_distance_a,
    input wire logic [lpp_pkg::DIST_W-1:0]        m_distance_b,
    input wire logic [lpp_pkg::DIST_W-1:0]        m_distance_c,
    input wire logic [lpp_pkg::DIST_W-1:0]        m_distance_d,
    input wire logic [lpp_pkg::FLAGS_W-1:0]       m_flags_a,
    input wire logic [lpp_pkg::FLAGS_W-1:0]       m_flags_b,
    input wire logic [lpp_pkg::FLAGS_W-1:0]       m_flags_c,
    input wire logic [lpp_pkg::FLAGS_W-1:0]       m_flags_d
);

    // A stalled result transaction holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_base_angle) && $stable(m_speed_raw))
        else $error("result changed while stalled");

    // Reset leaves the result channel empty
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // An empty result register never blocks the input
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with empty result register");

    // Flagged readings are reported as zero distance
    a_flag_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_flags_a == '0 || m_distance_a == '0)
                 && (m_flags_b == '0 || m_distance_b == '0)
                 && (m_flags_c == '0 || m_distance_c == '0)
                 && (m_flags_d == '0 || m_distance_d == '0))
        else $error("flagged reading with nonzero distance");

    // Angle is a multiple of four
    a_angle_scale: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_base_angle[lpp_pkg::ANGLE_SHIFT-1:0] == '0)
        else $error("base angle not a multiple of four");

endmodule

bind lidar_packet_parser lpp_checker u_lpp_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_ready      (s_ready),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_base_angle (m_base_angle),
    .m_speed_raw  (m_speed_raw),
    .m_distance_a (m_distance_a),
    .m_distance_b (m_distance_b),
    .m_distance_c (m_distance_c),
    .m_distance_d (m_distance_d),
    .m_flags_a    (m_flags_a),
    .m_flags_b    (m_flags_b),
    .m_flags_c    (m_flags_c),
    .m_flags_d    (m_flags_d)
);

`default_nettype wire
